// ===== hdl/lcdw_pkg.sv =====
// Shared types, command constants and the 5x7 font table for the LCD text and pixel writer.
// No dependencies; every other file of the block imports it.
package lcdw_pkg;

  localparam logic [1:0] MODE_GOTO_CELL   = 2'd0;
  localparam logic [1:0] MODE_GOTO_COLUMN = 2'd1;
  localparam logic [1:0] MODE_DRAW_CHAR   = 2'd2;
  localparam logic [1:0] MODE_SET_PIXEL   = 2'd3;

  localparam logic [7:0] CMD_PAGE       = 8'hB0;
  localparam logic [7:0] CMD_COLUMN_HI  = 8'h10;
  localparam logic [7:0] COLUMN_LO_MASK = 8'h0F;
  localparam logic [7:0] COLUMN_HI_MASK = 8'hF0;
  localparam logic [7:0] CELL_WIDTH     = 8'd6;
  localparam logic [7:0] GLYPH_FIRST    = 8'd32;
  localparam logic [7:0] GLYPH_LAST     = 8'd129;

  localparam logic [3:0] STEP_PAGE       = 4'd0;
  localparam logic [3:0] STEP_COLUMN_LO  = 4'd1;
  localparam logic [3:0] STEP_COLUMN_HI  = 4'd2;
  localparam logic [3:0] STEP_FIRST_DATA = 4'd3;
  localparam logic [3:0] STEP_BLANK      = 4'd8;

  typedef enum logic [1:0] {
    KIND_ADDR,
    KIND_CHAR,
    KIND_PIXEL
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [7:0]  column;
    logic [2:0]  page;
    logic [7:0]  code;
  } job_t;

  function automatic logic [39:0] glyph_bits(input logic [7:0] code);
    logic [7:0]  offset;
    logic [39:0] g;
    offset = code - GLYPH_FIRST;
    g = 40'h0;
    if (code >= GLYPH_FIRST && code <= GLYPH_LAST) begin
      unique case (offset[6:0])
        7'd0:  g = 40'h0000000000;  7'd1:  g = 40'h00002f0000;  7'd2:  g = 40'h0007000700;
        7'd3:  g = 40'h147f147f14;  7'd4:  g = 40'h242a7f2a12;  7'd5:  g = 40'h3234081626;
        7'd6:  g = 40'h3649552250;  7'd7:  g = 40'h0005030000;  7'd8:  g = 40'h001c224100;
        7'd9:  g = 40'h0041221c00;  7'd10: g = 40'h14083e0814;  7'd11: g = 40'h08083e0808;
        7'd12: g = 40'h0000503000;  7'd13: g = 40'h1010101010;  7'd14: g = 40'h0060600000;
        7'd15: g = 40'h2010080402;  7'd16: g = 40'h3e5149453e;  7'd17: g = 40'h00427f4000;
        7'd18: g = 40'h4261514946;  7'd19: g = 40'h2141454b31;  7'd20: g = 40'h1814127f10;
        7'd21: g = 40'h2745454539;  7'd22: g = 40'h3c4a494930;  7'd23: g = 40'h0171090503;
        7'd24: g = 40'h3649494936;  7'd25: g = 40'h064949291e;  7'd26: g = 40'h0036360000;
        7'd27: g = 40'h0056360000;  7'd28: g = 40'h0814224100;  7'd29: g = 40'h1414141414;
        7'd30: g = 40'h0041221408;  7'd31: g = 40'h0201510906;  7'd32: g = 40'h324959513e;
        7'd33: g = 40'h7e1111117e;  7'd34: g = 40'h7f49494936;  7'd35: g = 40'h3e41414122;
        7'd36: g = 40'h7f4141221c;  7'd37: g = 40'h7f49494941;  7'd38: g = 40'h7f09090901;
        7'd39: g = 40'h3e4149497a;  7'd40: g = 40'h7f0808087f;  7'd41: g = 40'h00417f4100;
        7'd42: g = 40'h2040413f01;  7'd43: g = 40'h7f08142241;  7'd44: g = 40'h7f40404040;
        7'd45: g = 40'h7f020c027f;  7'd46: g = 40'h7f0408107f;  7'd47: g = 40'h3e4141413e;
        7'd48: g = 40'h7f09090906;  7'd49: g = 40'h3e4151215e;  7'd50: g = 40'h7f09192946;
        7'd51: g = 40'h4649494931;  7'd52: g = 40'h01017f0101;  7'd53: g = 40'h3f4040403f;
        7'd54: g = 40'h1f2040201f;  7'd55: g = 40'h3f4038403f;  7'd56: g = 40'h6314081463;
        7'd57: g = 40'h0708700807;  7'd58: g = 40'h6151494543;  7'd59: g = 40'h007f414100;
        7'd60: g = 40'h552a552a55;  7'd61: g = 40'h0041417f00;  7'd62: g = 40'h0402010204;
        7'd63: g = 40'h4040404040;  7'd64: g = 40'h0001020400;  7'd65: g = 40'h2054545478;
        7'd66: g = 40'h7f48444438;  7'd67: g = 40'h3844444420;  7'd68: g = 40'h384444487f;
        7'd69: g = 40'h3854545418;  7'd70: g = 40'h087e090102;  7'd71: g = 40'h0c5252523e;
        7'd72: g = 40'h7f08040478;  7'd73: g = 40'h00447d4000;  7'd74: g = 40'h2040443d00;
        7'd75: g = 40'h7f10284400;  7'd76: g = 40'h00417f4000;  7'd77: g = 40'h7c04180478;
        7'd78: g = 40'h7c08040478;  7'd79: g = 40'h3844444438;  7'd80: g = 40'h7c14141408;
        7'd81: g = 40'h081414187c;  7'd82: g = 40'h7c08040408;  7'd83: g = 40'h4854545420;
        7'd84: g = 40'h043f444020;  7'd85: g = 40'h3c4040207c;  7'd86: g = 40'h1c2040201c;
        7'd87: g = 40'h3c4030403c;  7'd88: g = 40'h4428102844;  7'd89: g = 40'h0c5050503c;
        7'd90: g = 40'h4464544c44;  7'd91: g = 40'h007f3e1c08;  7'd92: g = 40'h081c3e7f00;
        7'd93: g = 40'h087c7e7c08;  7'd94: g = 40'h103e7e3e10;  7'd95: g = 40'h3e3e3e3e3e;
        7'd96: g = 40'h007f3e1c08;  7'd97: g = 40'h0e1111110e;
        default: g = 40'h0;
      endcase
    end
    return g;
  endfunction

endpackage

// ===== hdl/lcdw_front.sv =====
// Front end of the LCD writer: accepts request words, keeps the cursor and classifies
// each request into a job for the queue. Depends on lcdw_pkg.
module lcdw_front
  import lcdw_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] mode,
  input  logic [6:0] x,
  input  logic [5:0] y,
  input  logic [7:0] character,
  input  logic       hold,
  output logic       push_valid,
  input  logic       push_ready,
  output job_t       job
);

  logic [7:0] cursor_column, cursor_column_next;
  logic [2:0] cursor_page, cursor_page_next;
  logic [9:0] cell_column;
  logic       accept;

  assign in_ready   = push_ready && !hold;
  assign accept     = in_valid && in_ready;
  assign push_valid = accept;
  assign cell_column = {3'b000, x} * {2'b00, CELL_WIDTH};

  always_comb begin
    cursor_column_next = cursor_column;
    cursor_page_next   = cursor_page;
    job.kind   = KIND_ADDR;
    job.column = cursor_column;
    job.page   = cursor_page;
    job.code   = character;
    unique case (mode)
      MODE_GOTO_CELL: begin
        cursor_column_next = cell_column[7:0];
        cursor_page_next   = y[2:0];
        job.column = cell_column[7:0];
        job.page   = y[2:0];
      end
      MODE_GOTO_COLUMN: begin
        cursor_column_next = {1'b0, x};
        cursor_page_next   = y[2:0];
        job.column = {1'b0, x};
        job.page   = y[2:0];
      end
      MODE_DRAW_CHAR: begin
        cursor_column_next = cursor_column + CELL_WIDTH;
        job.kind = KIND_CHAR;
      end
      MODE_SET_PIXEL: begin
        cursor_column_next = {1'b0, x};
        cursor_page_next   = y[5:3];
        job.kind   = KIND_PIXEL;
        job.column = {1'b0, x};
        job.page   = y[5:3];
        job.code   = {5'b00000, y[2:0]};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_column <= '0;
      cursor_page   <= '0;
    end else if (accept) begin
      cursor_column <= cursor_column_next;
      cursor_page   <= cursor_page_next;
    end
  end

endmodule

// ===== hdl/lcdw_queue.sv =====
// Two-entry job queue between the front and back ends of the LCD writer.
// Depends on lcdw_pkg for the job type.
module lcdw_queue
  import lcdw_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  job_t din,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t dout
);

  job_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign push_ready = count != 2'd2;
  assign pop_valid  = count != 2'd0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign dout       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== hdl/lcdw_back.sv =====
// Back end of the LCD writer: sequences the address, glyph and pixel bytes of each job,
// owns the page shadow memory and its clearing pass, and drives the output register.
// Depends on lcdw_pkg.
module lcdw_back
  import lcdw_pkg::*;
#(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       pop_valid,
  output logic       pop_ready,
  input  job_t       job,
  output logic       clearing,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       is_data,
  output logic       last
);

  localparam int DEPTH = COLUMNS * PAGES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  function automatic logic [AW-1:0] shadow_index(input logic [7:0] c, input logic [2:0] p);
    return AW'(32'(c) * PAGES + 32'(p));
  endfunction

  function automatic logic stored(input logic [7:0] c, input logic [2:0] p);
    return ({1'b0, c} < 9'(COLUMNS)) && ({2'b00, p} < 5'(PAGES));
  endfunction

  logic [7:0]    shadow [DEPTH];
  logic [7:0]    rdata;
  logic [AW-1:0] clear_addr;
  logic          busy;
  job_t          cur;
  logic [3:0]    step;

  logic          load;
  logic          take;
  logic          emit;
  logic          emit_last;
  logic [7:0]    emit_byte;
  logic          emit_data;
  logic [7:0]    merged;
  logic [39:0]   glyph;
  logic [3:0]    glyph_step;
  logic [7:0]    glyph_col;
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic [AW-1:0] raddr;

  assign load      = !out_valid || out_ready;
  assign emit      = load && busy;
  assign take      = load && !clearing && (!busy || emit_last);
  assign pop_ready = take;
  assign raddr     = shadow_index(job.column, job.page);

  assign glyph      = glyph_bits(cur.code);
  assign glyph_step = step - STEP_FIRST_DATA;
  assign merged     = (8'd1 << cur.code[2:0]) | (stored(cur.column, cur.page) ? rdata : 8'h00);

  always_comb begin
    case (glyph_step[2:0])
      3'd0:    glyph_col = {glyph[38:32], 1'b0};
      3'd1:    glyph_col = {glyph[30:24], 1'b0};
      3'd2:    glyph_col = {glyph[22:16], 1'b0};
      3'd3:    glyph_col = {glyph[14:8], 1'b0};
      3'd4:    glyph_col = {glyph[6:0], 1'b0};
      default: glyph_col = 8'h00;
    endcase
  end

  always_comb begin
    emit_data = 1'b1;
    emit_last = 1'b0;
    emit_byte = 8'h00;
    unique case (step)
      STEP_PAGE: begin
        emit_data = 1'b0;
        emit_byte = CMD_PAGE | {5'b00000, cur.page};
      end
      STEP_COLUMN_LO: begin
        emit_data = 1'b0;
        emit_byte = cur.column & COLUMN_LO_MASK;
      end
      STEP_COLUMN_HI: begin
        emit_data = 1'b0;
        emit_byte = CMD_COLUMN_HI | ((cur.column & COLUMN_HI_MASK) >> 4);
        emit_last = cur.kind == KIND_ADDR;
      end
      default: begin
        if (cur.kind == KIND_PIXEL) begin
          emit_byte = merged;
          emit_last = 1'b1;
        end else if (step == STEP_BLANK) begin
          emit_byte = 8'h00;
          emit_last = 1'b1;
        end else begin
          emit_byte = glyph_col;
        end
      end
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = clear_addr;
    wdata = 8'h00;
    if (clearing) begin
      we = 1'b1;
    end else if (emit && cur.kind == KIND_PIXEL && step == STEP_FIRST_DATA
                 && stored(cur.column, cur.page)) begin
      we    = 1'b1;
      waddr = shadow_index(cur.column, cur.page);
      wdata = merged;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      shadow[waddr] <= wdata;
    end
    if (take) begin
      rdata <= (we && waddr == raddr) ? wdata : shadow[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      if (clear_addr == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end else begin
        clear_addr <= clear_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      step      <= STEP_PAGE;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= busy;
      end
      if (take) begin
        busy <= pop_valid;
        step <= STEP_PAGE;
      end else if (emit) begin
        step <= step + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur <= job;
    end
    if (emit) begin
      out_byte <= emit_byte;
      is_data  <= emit_data;
      last     <= emit_last;
    end
  end

endmodule

// ===== hdl/lcd_text_pixel_command_writer_core.sv =====
// Top level of the LCD text and pixel writer: front end, job queue and back end.
// Depends on lcdw_pkg, lcdw_front, lcdw_queue and lcdw_back.
//
// Usage:
//   The input channel (in_valid/in_ready) takes one request word: mode, x, y, character.
//   The output channel (out_valid/out_ready) gives the display stream one word at a time:
//   out_byte, is_data (data or command) and last on the final word of a request.
//   Goto requests give 3 words, set pixel gives 4, draw character gives 9.
//   The back end sends one word per cycle while out_ready is high; while jobs wait in the
//   queue, requests follow each other with no gap between streams. With the back end
//   idle, a request passes the queue and the job register before its first word is
//   registered. A two-entry queue lets the front keep accepting while the back end works.
//   Set pixel reads and writes the page shadow memory through one write and one
//   registered read port; the read is issued when the job enters the back end.
//   After reset the shadow memory is cleared one byte per cycle, all COLUMNS*PAGES bytes
//   (1024 by default), and in_ready stays low during that pass. The cursor resets to
//   column 0, page 0.
//   When out_ready is low the current word holds; the back end stops, the queue fills,
//   and in_ready drops once the queue is full.
module lcd_text_pixel_command_writer_core
  import lcdw_pkg::*;
#(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] mode,
  input  logic [6:0] x,
  input  logic [5:0] y,
  input  logic [7:0] character,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       is_data,
  output logic       last
);

  logic push_valid;
  logic push_ready;
  job_t push_job;
  logic pop_valid;
  logic pop_ready;
  job_t pop_job;
  logic clearing;

  lcdw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .x          (x),
    .y          (y),
    .character  (character),
    .hold       (clearing),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .job        (push_job)
  );

  lcdw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .din        (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .dout       (pop_job)
  );

  lcdw_back #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .job       (pop_job),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .is_data   (is_data),
    .last      (last)
  );

endmodule
